// ===== hw/rtl/qlsds_pkg.sv =====
// shared constants and types for the quad-lane dac frame serializer
package qlsds_pkg;

    localparam int FRAME_BITS    = 24;
    localparam int BIT_W         = $clog2(FRAME_BITS);
    localparam int MAX_LANES     = 4;
    localparam int LANES_DEFAULT = 4;
    localparam int CODE_W        = 16;
    localparam int FRAME_PAIR_W  = 2 * FRAME_BITS;

    // input tdata layout: code_a0, code_b0 .. code_a3, code_b3, raw_command
    localparam int S_TDATA_W   = 2 * MAX_LANES * CODE_W + FRAME_BITS;
    localparam int RAW_LSB     = 2 * MAX_LANES * CODE_W;
    // output tdata layout: lane_bits, frame_index, bit_index, load_hold, frame_end
    localparam int M_FIELD_W   = MAX_LANES + 1 + BIT_W + 1 + 1;
    localparam int M_TDATA_W   = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [FRAME_BITS-1:0] CMD_WRITE_UPDATE = FRAME_BITS'(3 << 19);
    localparam logic [FRAME_BITS-1:0] ADDR_CH_A        = FRAME_BITS'(0 << 16);
    localparam logic [FRAME_BITS-1:0] ADDR_CH_B        = FRAME_BITS'(1 << 16);
    localparam logic [BIT_W-1:0]      BIT_FIRST        = BIT_W'(FRAME_BITS - 1);

    localparam logic KIND_UPDATE    = 1'b0;
    localparam logic KIND_BROADCAST = 1'b1;

    typedef struct packed {
        logic             frame_index;
        logic [BIT_W-1:0] bit_index;
        logic             load_hold;
        logic             frame_end;
        logic             last;
    } ctl_t;

endpackage

// ===== hw/rtl/qlsds_lane.sv =====
// one data lane: holds both frames of its chip, or the broadcast frame, and shifts them out msb first
module qlsds_lane
(
    input  logic                              clk,
    input  logic                              load,
    input  logic                              shift,
    input  logic                              kind,
    input  logic [qlsds_pkg::CODE_W-1:0]      code_a,
    input  logic [qlsds_pkg::CODE_W-1:0]      code_b,
    input  logic [qlsds_pkg::FRAME_BITS-1:0]  raw_command,
    output logic                              lane_bit
);
    import qlsds_pkg::*;

    logic [FRAME_PAIR_W-1:0] sreg_reg;
    logic [FRAME_PAIR_W-1:0] sreg_next;
    logic [FRAME_BITS-1:0]   frame_a;
    logic [FRAME_BITS-1:0]   frame_b;

    assign frame_a = CMD_WRITE_UPDATE | ADDR_CH_A | FRAME_BITS'(code_a);
    assign frame_b = CMD_WRITE_UPDATE | ADDR_CH_B | FRAME_BITS'(code_b);

    always_comb
    begin
        sreg_next = sreg_reg;
        if (load)
        begin
            if (kind == KIND_BROADCAST)
            begin
                sreg_next = {raw_command, {FRAME_BITS{1'b0}}};
            end
            else
            begin
                sreg_next = {frame_a, frame_b};
            end
        end
        else if (shift)
        begin
            sreg_next = {sreg_reg[FRAME_PAIR_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        sreg_reg <= sreg_next;
    end

    assign lane_bit = sreg_reg[FRAME_PAIR_W-1];

endmodule

// ===== hw/rtl/qlsds_seq.sv =====
// bit and frame sequencer shared by all lanes
module qlsds_seq
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic             kind,
    input  logic             advance,
    output logic             busy,
    output qlsds_pkg::ctl_t  ctl
);
    import qlsds_pkg::*;

    logic             busy_reg,  busy_next;
    logic             frame_reg, frame_next;
    logic             bcast_reg, bcast_next;
    logic [BIT_W-1:0] bit_reg,   bit_next;
    logic             at_end;
    logic             item_last;

    assign at_end    = (bit_reg == '0);
    assign item_last = at_end && (bcast_reg || frame_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        frame_next = frame_reg;
        bcast_next = bcast_reg;
        bit_next   = bit_reg;
        if (load)
        begin
            busy_next  = 1'b1;
            frame_next = 1'b0;
            bcast_next = kind;
            bit_next   = BIT_FIRST;
        end
        else if (advance)
        begin
            if (item_last)
            begin
                busy_next = 1'b0;
            end
            else if (at_end)
            begin
                // channel b frame follows channel a
                frame_next = 1'b1;
                bit_next   = BIT_FIRST;
            end
            else
            begin
                bit_next = bit_reg - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            frame_reg <= 1'b0;
            bcast_reg <= 1'b0;
            bit_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            frame_reg <= frame_next;
            bcast_reg <= bcast_next;
            bit_reg   <= bit_next;
        end
    end

    assign busy            = busy_reg;
    assign ctl.frame_index = frame_reg;
    assign ctl.bit_index   = bit_reg;
    assign ctl.load_hold   = !bcast_reg;
    assign ctl.frame_end   = at_end;
    assign ctl.last        = item_last;

endmodule

// ===== hw/rtl/qlsds_out.sv =====
// merging stage: joins lane bits with sequencer status into the output register
module qlsds_out
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic [qlsds_pkg::MAX_LANES-1:0]   lane_bits,
    input  qlsds_pkg::ctl_t                   ctl,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [qlsds_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                              m_tlast
);
    import qlsds_pkg::*;

    logic                 valid_reg, valid_next;
    logic [M_TDATA_W-1:0] data_reg;
    logic                 last_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            data_reg <= M_TDATA_W'({ctl.frame_end, ctl.load_hold, ctl.bit_index,
                                    ctl.frame_index, lane_bits});
            last_reg <= ctl.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== hw/rtl/quad_lane_spi_dac_frame_serializer_top.sv =====
// top level of the quad-lane spi dac frame serializer
//
// each request drives four dual-channel 16-bit dacs that share bit clock and frame
// select, one data lane per chip. an update request (tuser kind 0) becomes two
// 24-bit frames sent msb first: channel a (command 3, address 0, code) then
// channel b (command 3, address 1, code), 48 output beats with load_hold high.
// a broadcast request (kind 1) sends raw_command on every active lane as 24
// beats with load_hold low. one output beat is one bit clock. the lane registers
// shift one bit per cycle while the output accepts beats; the next request is
// taken in the cycle the current item's last beat enters the output register,
// so items stream with no gap. lanes at or above min(LANES, 4) are driven 0.
module quad_lane_spi_dac_frame_serializer_top
#(
    parameter int LANES = qlsds_pkg::LANES_DEFAULT
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // code_a0, code_b0, code_a1, code_b1, code_a2, code_b2, code_a3, code_b3,
    // raw_command (lowest bits first)
    input  logic [qlsds_pkg::S_TDATA_W-1:0]   s_tdata,
    // kind
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // lane_bits, frame_index, bit_index, load_hold, frame_end, zero fill
    // (lowest bits first)
    output logic [qlsds_pkg::M_TDATA_W-1:0]   m_tdata,
    // last
    output logic                              m_tlast
);
    import qlsds_pkg::*;

    localparam int NL = (LANES > MAX_LANES) ? MAX_LANES : LANES;

    logic                  load;
    logic                  advance;
    logic                  busy;
    ctl_t                  ctl;
    logic [MAX_LANES-1:0]  lane_bits;

    // while busy, a beat moves into the output register whenever that register is free
    assign advance  = busy && (!m_tvalid || m_tready);
    // free to load when idle, or when the final beat is moving into the output register this cycle
    assign s_tready = !busy || (advance && ctl.last);
    assign load     = s_tvalid && s_tready;

    qlsds_seq u_seq
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (load),
        .kind    (s_tuser[0]),
        .advance (advance),
        .busy    (busy),
        .ctl     (ctl)
    );

    // one shift lane per active chip, unused lanes tied low
    for (genvar i = 0; i < MAX_LANES; i++)
    begin : g_lane
        if (i < NL)
        begin : g_on
            qlsds_lane u_lane
            (
                .clk         (clk),
                .load        (load),
                .shift       (advance),
                .kind        (s_tuser[0]),
                .code_a      (s_tdata[2*CODE_W*i +: CODE_W]),
                .code_b      (s_tdata[2*CODE_W*i+CODE_W +: CODE_W]),
                .raw_command (s_tdata[RAW_LSB +: FRAME_BITS]),
                .lane_bit    (lane_bits[i])
            );
        end
        else
        begin : g_off
            assign lane_bits[i] = 1'b0;
        end
    end

    qlsds_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .lane_bits (lane_bits),
        .ctl       (ctl),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== hw/rtl/qlsds_checker.sv =====
// port-level checker for the serializer, bound to the top level
module qlsds_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [qlsds_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                              m_tlast
);
    import qlsds_pkg::*;

    logic [BIT_W-1:0] bit_index;
    logic             frame_index;
    logic             load_hold;
    logic             frame_end;

    assign frame_index = m_tdata[MAX_LANES];
    assign bit_index   = m_tdata[MAX_LANES+1 +: BIT_W];
    assign load_hold   = m_tdata[MAX_LANES+1+BIT_W];
    assign frame_end   = m_tdata[MAX_LANES+2+BIT_W];

    // a stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (bit_index <= BIT_FIRST) && (frame_end == (bit_index == '0)))
        else $error("bit index out of range or frame end misplaced");

    // the last beat ends channel b of an update, or the single broadcast frame
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> frame_end && (frame_index == load_hold))
        else $error("last beat in wrong place");

    a_bcast: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !load_hold |-> !frame_index)
        else $error("broadcast beat in second frame");

endmodule

bind quad_lane_spi_dac_frame_serializer_top qlsds_checker u_qlsds_checker (.*);

// ===== verif/tb_top.sv =====
// self-checking testbench for the quad-lane spi dac frame serializer
`timescale 1ns / 100ps

module tb_top;

    import qlsds_pkg::*;

    localparam int NUM_LANES    = LANES_DEFAULT;
    localparam int ACTIVE_LANES = (NUM_LANES > MAX_LANES) ? MAX_LANES : NUM_LANES;
    localparam logic [MAX_LANES-1:0] ACTIVE_MASK = MAX_LANES'((1 << ACTIVE_LANES) - 1);

    // output tdata field positions
    localparam int FRAME_POS = MAX_LANES;
    localparam int BIT_LSB   = MAX_LANES + 1;
    localparam int HOLD_POS  = BIT_LSB + BIT_W;
    localparam int END_POS   = HOLD_POS + 1;

    localparam int STALL_LIMIT  = 4000;
    localparam int HOLD_OFF_LEN = 400;
    localparam int RANDOM_ITEMS = 300;

    typedef struct {
        logic [MAX_LANES-1:0] lane_bits;
        logic                 frame_index;
        logic [BIT_W-1:0]     bit_index;
        logic                 load_hold;
        logic                 frame_end;
        logic                 last;
    } dac_beat_t;

    // expands requests into bit clocks and checks them in order
    class dac_frame_tracker;
        dac_beat_t beats_due[$];
        int        mismatches;
        int        beats_seen;

        function new();
            mismatches = 0;
            beats_seen = 0;
        endfunction

        function int outstanding();
            return beats_due.size();
        endfunction

        function void note_request(logic kind, logic [S_TDATA_W-1:0] payload);
            logic [FRAME_BITS-1:0] raw;
            logic [FRAME_BITS-1:0] word [MAX_LANES];
            dac_beat_t             beat;
            raw = payload[RAW_LSB +: FRAME_BITS];
            if (kind == KIND_BROADCAST)
            begin
                // same raw command on every active lane, load strobe left low
                for (int b = FRAME_BITS - 1; b >= 0; b--)
                begin
                    beat.lane_bits   = raw[b] ? ACTIVE_MASK : '0;
                    beat.frame_index = 1'b0;
                    beat.bit_index   = BIT_W'(b);
                    beat.load_hold   = 1'b0;
                    beat.frame_end   = (b == 0);
                    beat.last        = (b == 0);
                    beats_due.push_back(beat);
                end
            end
            else
            begin
                // channel a frame, then channel b frame, msb first
                for (int f = 0; f < 2; f++)
                begin
                    for (int i = 0; i < MAX_LANES; i++)
                        word[i] = CMD_WRITE_UPDATE | (f ? ADDR_CH_B : ADDR_CH_A)
                                  | FRAME_BITS'(payload[(2*i+f)*CODE_W +: CODE_W]);
                    for (int b = FRAME_BITS - 1; b >= 0; b--)
                    begin
                        beat.lane_bits = '0;
                        for (int i = 0; i < ACTIVE_LANES; i++)
                            beat.lane_bits[i] = word[i][b];
                        beat.frame_index = f[0];
                        beat.bit_index   = BIT_W'(b);
                        beat.load_hold   = 1'b1;
                        beat.frame_end   = (b == 0);
                        beat.last        = (f == 1 && b == 0);
                        beats_due.push_back(beat);
                    end
                end
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got)
            begin
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] word, logic tlast);
            dac_beat_t want;
            beats_seen++;
            if (beats_due.size() == 0)
            begin
                $display("%0t: output beat with nothing pending, expected none actual %0h/%0b",
                         $time, word, tlast);
                mismatches++;
                return;
            end
            want = beats_due.pop_front();
            compare_field("lane_bits", want.lane_bits, word[MAX_LANES-1:0]);
            compare_field("frame_index", want.frame_index, word[FRAME_POS]);
            compare_field("bit_index", want.bit_index, word[BIT_LSB +: BIT_W]);
            compare_field("load_hold", want.load_hold, word[HOLD_POS]);
            compare_field("frame_end", want.frame_end, word[END_POS]);
            compare_field("zero fill", 0, int'(word >> M_FIELD_W));
            compare_field("last", want.last, tlast);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    dac_frame_tracker tracker = new();

    bit source_steady = 1'b0;
    bit sink_steady   = 1'b0;
    int sink_hold_left = 0;
    int updates_sent = 0;
    int broadcasts_sent = 0;

    always #4 clk = ~clk;

    quad_lane_spi_dac_frame_serializer_top #(
        .LANES (NUM_LANES)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // random idle cycles, then offer one request and hold it until taken
    task automatic send_request(input logic kind, input logic [S_TDATA_W-1:0] payload);
        while (!source_steady && $urandom_range(99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= payload;
        s_tuser  <= kind;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(kind, payload);
        if (kind == KIND_BROADCAST)
            broadcasts_sent++;
        else
            updates_sent++;
    endtask

    // lowers valid and waits for every pending bit clock to come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    function automatic logic [S_TDATA_W-1:0] random_payload();
        logic [S_TDATA_W-1:0] p;
        for (int i = 0; i < 2 * MAX_LANES; i++)
            case ($urandom_range(7))
                0:       p[i*CODE_W +: CODE_W] = '0;
                1:       p[i*CODE_W +: CODE_W] = '1;
                default: p[i*CODE_W +: CODE_W] = CODE_W'($urandom);
            endcase
        case ($urandom_range(7))
            0:       p[RAW_LSB +: FRAME_BITS] = '0;
            1:       p[RAW_LSB +: FRAME_BITS] = '1;
            default: p[RAW_LSB +: FRAME_BITS] = FRAME_BITS'($urandom);
        endcase
        return p;
    endfunction

    // output side: random backpressure plus an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_left > 0)
            begin
                m_tready <= 1'b0;
                sink_hold_left--;
            end
            else
                m_tready <= sink_steady || ($urandom_range(99) >= 37);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_beat(m_tdata, m_tlast);
    end

    // ends the run if no request or bit clock moves for too long
    int quiet_cycles = 0;
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d bit clocks still pending",
                     $time, STALL_LIMIT, tracker.outstanding());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        logic kind;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = KIND_UPDATE;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, distinct codes per lane, broadcast patterns
        send_request(KIND_UPDATE, '0);
        send_request(KIND_UPDATE, '1);
        send_request(KIND_UPDATE, {24'h123456, 16'hFF00, 16'h00FF, 16'h5A5A, 16'hA5A5,
                                   16'hFFFE, 16'h7FFF, 16'h8000, 16'h0001});
        send_request(KIND_BROADCAST, {24'h000000, {8{16'hFFFF}}});
        send_request(KIND_BROADCAST, {24'hFFFFFF, {8{16'h0000}}});
        send_request(KIND_BROADCAST, {24'h800000, {8{16'h1234}}});
        send_request(KIND_BROADCAST, {24'h000001, {8{16'hFFFF}}});
        send_request(KIND_BROADCAST, {24'hA5A5A5, {8{16'h0000}}});
        send_request(KIND_UPDATE, {24'hFFFFFF, 16'h0001, 16'h8000, 16'h0002, 16'h4000,
                                   16'h0004, 16'h2000, 16'h0008, 16'h1000});
        send_request(KIND_BROADCAST, {24'h5A5A5A, {4{16'hAAAA, 16'h5555}}});
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 80)
            begin
                // hold the output back while requests keep coming
                sink_hold_left = HOLD_OFF_LEN;
                source_steady  = 1'b1;
            end
            if (n == 95)
                source_steady = 1'b0;
            if (n == 150)
                wait_drained();
            if (n == 180)
            begin
                source_steady = 1'b1;
                sink_steady   = 1'b1;
            end
            if (n == 240)
            begin
                source_steady = 1'b0;
                sink_steady   = 1'b0;
            end
            kind = ($urandom_range(99) < 30) ? KIND_BROADCAST : KIND_UPDATE;
            send_request(kind, random_payload());
        end

        wait_drained();
        repeat (64) @(posedge clk);

        $display("run covered %0d update and %0d broadcast requests, %0d bit clocks checked",
                 updates_sent, broadcasts_sent, tracker.beats_seen);
        $display("with random stalls, an output hold-off under load and a full drain pause");
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
